/* rtl/tpes_pkg.sv */
// Shared constants and types for the timed priority event scheduler.
// No dependencies; the interfaces, the top level and the bench refer to it by scoped names.
package tpes_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int SLOT_BITS  = $clog2(NUM_SLOTS);
  localparam int TIME_BITS  = 48;
  localparam int DELAY_BITS = 32;
  localparam int INFO_BITS  = 16;
  localparam int TAG_BITS   = 8;
  localparam int LEVEL_BITS = 3;
  localparam int MASK_BITS  = 8;
  localparam int TABLE_BITS = MASK_BITS * (1 << LEVEL_BITS);

  localparam logic [TIME_BITS-1:0]  TIME_MAX    = '1;
  localparam logic [TABLE_BITS-1:0] TABLE_RESET = TABLE_BITS'(64'h1_FFFF_FFFF);

  localparam logic CMD_REGISTER = 1'b0;
  localparam logic CMD_FIRE     = 1'b1;

  // One slot entry as held in the slot memory.
  typedef struct packed {
    logic [TIME_BITS-1:0] due;
    logic [INFO_BITS-1:0] info;
    logic [TAG_BITS-1:0]  tag;
  } slot_rec_t;

endpackage

/* rtl/tpes_in_if.sv */
// Input channel of the event scheduler: valid/ready plus one command word.
// Depends on tpes_pkg for the field widths.
interface tpes_in_if;
  logic                             valid;
  logic                             ready;
  logic                             command;
  logic [tpes_pkg::LEVEL_BITS-1:0]  level;
  logic [tpes_pkg::DELAY_BITS-1:0]  delay;
  logic [tpes_pkg::INFO_BITS-1:0]   event_info;
  logic [tpes_pkg::TAG_BITS-1:0]    handler_tag;
  logic [tpes_pkg::TIME_BITS-1:0]   now;

  modport source (output valid, command, level, delay, event_info, handler_tag, now,
                  input ready);
  modport sink   (input valid, command, level, delay, event_info, handler_tag, now,
                  output ready);
endinterface

/* rtl/tpes_out_if.sv */
// Output channel of the event scheduler: valid/ready plus one result word.
// Depends on tpes_pkg for the field widths.
interface tpes_out_if;
  logic                             valid;
  logic                             ready;
  logic                             fired;
  logic [tpes_pkg::LEVEL_BITS-1:0]  fired_slot;
  logic [tpes_pkg::INFO_BITS-1:0]   fired_info;
  logic [tpes_pkg::TAG_BITS-1:0]    fired_handler;
  logic [tpes_pkg::NUM_SLOTS-1:0]   pending_bits;
  logic [tpes_pkg::TIME_BITS-1:0]   next_due;

  modport source (output valid, fired, fired_slot, fired_info, fired_handler, pending_bits,
                  next_due, input ready);
  modport sink   (input valid, fired, fired_slot, fired_info, fired_handler, pending_bits,
                  next_due, output ready);
endinterface

/* rtl/tpes_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tpes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/timed_priority_event_scheduler.sv */
// Timed priority event scheduler: top level.
// Flow: a register command passes ST_REG, then ST_RESULT; a fire passes ST_FCHK, then
// ST_SCAN (reading the slot RAM one slot a cycle) unless the scan is skipped, then ST_RESULT.
// One word at a time: a new word is taken only back in ST_IDLE, and ST_RESULT waits while
// the previous result still waits in the output register.
// Reset (rst, synchronous): nothing pending, earliest due 0, mask table 0x1FFFFFFFF.
module timed_priority_event_scheduler (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tpes_pkg::TABLE_BITS-1:0]    cfg_wdata,
  tpes_in_if.sink                            item,
  tpes_out_if.source                         result
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REG    = 3'd1;
  localparam logic [2:0] ST_FCHK   = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_RESULT = 3'd4;

  localparam int CNT_BITS = tpes_pkg::SLOT_BITS + 1;

  logic [2:0] state;

  // Configuration
  logic [tpes_pkg::TABLE_BITS-1:0] mask_table;

  // Latched command word
  logic                              cmd;
  logic [tpes_pkg::LEVEL_BITS-1:0]   lvl;
  logic [tpes_pkg::DELAY_BITS-1:0]   dly;
  logic [tpes_pkg::INFO_BITS-1:0]    info;
  logic [tpes_pkg::TAG_BITS-1:0]     tag;
  logic [tpes_pkg::TIME_BITS-1:0]    now;

  // Scheduler state held in flops; per-slot payload lives in the RAM.
  // Slot memory contents are not cleared; a slot's read data is only used while it is pending.
  logic [tpes_pkg::NUM_SLOTS-1:0]    pend;
  logic [tpes_pkg::TIME_BITS-1:0]    earliest;

  // Working result of the current command
  logic                              fired;
  logic [tpes_pkg::LEVEL_BITS-1:0]   fslot;
  logic [tpes_pkg::INFO_BITS-1:0]    finfo;
  logic [tpes_pkg::TAG_BITS-1:0]     ftag;
  logic [tpes_pkg::NUM_SLOTS-1:0]    scan_mask;

  // Scan pipeline: issue index and the index whose read data is arriving
  logic [CNT_BITS-1:0]               issue_idx;
  logic                              chk_vld;
  logic [tpes_pkg::SLOT_BITS-1:0]    chk_idx;

  // RAM ports
  logic                              ram_we;
  logic                              ram_re;
  logic [tpes_pkg::SLOT_BITS-1:0]    ram_waddr;
  logic [tpes_pkg::SLOT_BITS-1:0]    ram_raddr;
  tpes_pkg::slot_rec_t               ram_wdata;
  tpes_pkg::slot_rec_t               ram_rdata;

  // Output register
  logic                              out_valid;

  logic [tpes_pkg::TIME_BITS:0]      due_sum;
  logic [tpes_pkg::TIME_BITS-1:0]    due;
  logic                              slot_ok;
  logic [tpes_pkg::MASK_BITS-1:0]    lvl_mask;
  logic [tpes_pkg::NUM_SLOTS-1:0]    lvl_mask_slots;
  logic                              out_free;

  assign item.ready = (state == ST_IDLE);
  assign out_free   = !out_valid || result.ready;

  // Due time: now + delay, saturating at the top of the time range
  assign due_sum = {1'b0, now} + (tpes_pkg::TIME_BITS + 1)'(dly);
  assign due     = due_sum[tpes_pkg::TIME_BITS] ? tpes_pkg::TIME_MAX
                                                : due_sum[tpes_pkg::TIME_BITS-1:0];

  // Slot number in range and slot free
  assign slot_ok = ((CNT_BITS + tpes_pkg::LEVEL_BITS)'(lvl)
                    < (CNT_BITS + tpes_pkg::LEVEL_BITS)'(tpes_pkg::NUM_SLOTS))
                   && !pend[lvl[tpes_pkg::SLOT_BITS-1:0]];

  // Enable mask for the CPU level; slots past the byte are never enabled
  assign lvl_mask       = mask_table[{lvl, 3'b000} +: tpes_pkg::MASK_BITS];
  assign lvl_mask_slots = tpes_pkg::NUM_SLOTS'(lvl_mask);

  // Register writes its slot straight in; fire scans by reading one slot a cycle
  assign ram_we    = (state == ST_REG) && slot_ok;
  assign ram_waddr = lvl[tpes_pkg::SLOT_BITS-1:0];
  assign ram_wdata = '{due: due, info: info, tag: tag};
  assign ram_re    = (state == ST_SCAN) && (issue_idx < CNT_BITS'(tpes_pkg::NUM_SLOTS));
  assign ram_raddr = issue_idx[tpes_pkg::SLOT_BITS-1:0];

  tpes_ram #(
    .WIDTH ($bits(tpes_pkg::slot_rec_t)),
    .DEPTH (tpes_pkg::NUM_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_table <= tpes_pkg::TABLE_RESET;
    end else if (cfg_we) begin
      mask_table <= cfg_wdata;
    end
  end

  // Latch the accepted word
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      cmd  <= item.command;
      lvl  <= item.level;
      dly  <= item.delay;
      info <= item.event_info;
      tag  <= item.handler_tag;
      now  <= item.now;
    end
  end

  // Main sequencer. Writes happen only in ST_REG and reads only in ST_SCAN of a later
  // command, so the RAM never sees a read and write to the same slot in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pend      <= '0;
      earliest  <= '0;
      out_valid <= 1'b0;
      chk_vld   <= 1'b0;
      issue_idx <= '0;
    end else begin
      // Load a new result when the register frees up, else drop the taken one
      if (state == ST_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          fired <= 1'b0;
          fslot <= '0;
          finfo <= '0;
          ftag  <= '0;
          if (item.valid) begin
            state <= (item.command == tpes_pkg::CMD_FIRE) ? ST_FCHK : ST_REG;
          end
        end
        ST_REG: begin
          // Arm a free slot; track the earliest due time
          if (slot_ok) begin
            pend[lvl[tpes_pkg::SLOT_BITS-1:0]] <= 1'b1;
            if (pend == '0 || due < earliest) begin
              earliest <= due;
            end
          end
          state <= ST_RESULT;
        end
        ST_FCHK: begin
          // Skip the scan when nothing enabled is pending or nothing can be due yet
          if (((lvl_mask_slots & pend) != '0) && (now >= earliest)) begin
            earliest  <= tpes_pkg::TIME_MAX;
            scan_mask <= lvl_mask_slots;
            issue_idx <= '0;
            chk_vld   <= 1'b0;
            state     <= ST_SCAN;
          end else begin
            state <= ST_RESULT;
          end
        end
        ST_SCAN: begin
          if (ram_re) begin
            issue_idx <= issue_idx + CNT_BITS'(1);
          end
          chk_vld <= ram_re;
          chk_idx <= ram_raddr;
          if (chk_vld) begin
            if (pend[chk_idx]) begin
              if (scan_mask[chk_idx] && now >= ram_rdata.due) begin
                // Release this slot; no further slot may fire on this command
                fired         <= 1'b1;
                fslot         <= tpes_pkg::LEVEL_BITS'(chk_idx);
                finfo         <= ram_rdata.info;
                ftag          <= ram_rdata.tag;
                pend[chk_idx] <= 1'b0;
                scan_mask     <= '0;
              end else if (ram_rdata.due < earliest) begin
                earliest <= ram_rdata.due;
              end
            end
            if (chk_idx == tpes_pkg::SLOT_BITS'(tpes_pkg::NUM_SLOTS - 1)) begin
              state <= ST_RESULT;
            end
          end
        end
        ST_RESULT: begin
          // Hold until the output register is free
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (state == ST_RESULT && out_free) begin
      result.fired         <= fired;
      result.fired_slot    <= fslot;
      result.fired_info    <= finfo;
      result.fired_handler <= ftag;
      result.pending_bits  <= pend;
      result.next_due      <= (pend == '0) ? tpes_pkg::TIME_MAX : earliest;
    end
  end

  assign result.valid = out_valid;

endmodule

/* test/timed_priority_event_scheduler_test.sv */
// Self-checking bench for the timed priority event scheduler: directed and random command
// words, an in-bench prediction of every result word, several mask tables and idle patterns.
// Depends on tpes_pkg, tpes_in_if, tpes_out_if and the scheduler RTL.
`timescale 1ns / 1ps

module timed_priority_event_scheduler_test;

  // Cycles to let pass after the last result before touching the table or ending.
  localparam int SETTLE_CYCLES = 12;

  // One result word as predicted.
  typedef struct packed {
    logic                            fired;
    logic [tpes_pkg::LEVEL_BITS-1:0] slot;
    logic [tpes_pkg::INFO_BITS-1:0]  info;
    logic [tpes_pkg::TAG_BITS-1:0]   tag;
    logic [tpes_pkg::NUM_SLOTS-1:0]  pending;
    logic [tpes_pkg::TIME_BITS-1:0]  next_due;
  } release_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [tpes_pkg::TABLE_BITS-1:0] cfg_wdata;

  tpes_in_if  in_ch ();
  tpes_out_if out_ch ();

  timed_priority_event_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (in_ch),
    .result    (out_ch)
  );

  // 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idle controls, changed between tests: percent chance of a sender gap before
  // each word and of the receiver holding ready low in a given cycle.
  int gap_pct   = 0;
  int stall_pct = 0;
  int mismatches = 0;

  // Predicted scheduler state: mask table, armed slots, per-slot contents and the
  // tracked earliest due time.
  logic [tpes_pkg::TABLE_BITS-1:0] level_masks;
  logic [tpes_pkg::NUM_SLOTS-1:0]  armed;
  logic [tpes_pkg::TIME_BITS-1:0]  slot_due  [tpes_pkg::NUM_SLOTS];
  logic [tpes_pkg::INFO_BITS-1:0]  slot_word [tpes_pkg::NUM_SLOTS];
  logic [tpes_pkg::TAG_BITS-1:0]   slot_tag  [tpes_pkg::NUM_SLOTS];
  logic [tpes_pkg::TIME_BITS-1:0]  soonest_due;

  // Results still owed by the block, oldest first.
  release_t release_q [$];

  // Advance the predicted state by one accepted command word and queue the
  // result word it must produce.
  task automatic predict_release(input logic cmd,
                                 input logic [tpes_pkg::LEVEL_BITS-1:0] lvl,
                                 input logic [tpes_pkg::DELAY_BITS-1:0] dly,
                                 input logic [tpes_pkg::INFO_BITS-1:0] info,
                                 input logic [tpes_pkg::TAG_BITS-1:0] tag,
                                 input logic [tpes_pkg::TIME_BITS-1:0] now);
    logic [tpes_pkg::TIME_BITS:0]   sum;
    logic [tpes_pkg::TIME_BITS-1:0] due;
    logic [tpes_pkg::MASK_BITS-1:0] enable;
    release_t r;
    r = '0;
    if (cmd == tpes_pkg::CMD_REGISTER) begin
      // A pending slot keeps its event; the new one is dropped.
      if (!armed[lvl]) begin
        sum = {1'b0, now} + (tpes_pkg::TIME_BITS + 1)'(dly);
        due = sum[tpes_pkg::TIME_BITS] ? tpes_pkg::TIME_MAX : sum[tpes_pkg::TIME_BITS-1:0];
        slot_due[lvl]  = due;
        slot_word[lvl] = info;
        slot_tag[lvl]  = tag;
        if (armed == '0 || due < soonest_due) soonest_due = due;
        armed[lvl] = 1'b1;
      end
    end else begin
      enable = level_masks[lvl * tpes_pkg::MASK_BITS +: tpes_pkg::MASK_BITS];
      // Nothing happens unless some enabled slot is pending and the clock has
      // reached the tracked earliest due time.
      if ((enable & armed) != '0 && now >= soonest_due) begin
        soonest_due = tpes_pkg::TIME_MAX;
        for (int s = 0; s < tpes_pkg::NUM_SLOTS; s++) begin
          if (armed[s]) begin
            if (enable[s] && now >= slot_due[s]) begin
              // Release the first due slot only; later slots just feed the minimum.
              r.fired   = 1'b1;
              r.slot    = tpes_pkg::LEVEL_BITS'(s);
              r.info    = slot_word[s];
              r.tag     = slot_tag[s];
              armed[s]  = 1'b0;
              enable    = '0;
            end else if (slot_due[s] < soonest_due) begin
              soonest_due = slot_due[s];
            end
          end
        end
      end
    end
    r.pending  = armed;
    r.next_due = (armed == '0) ? tpes_pkg::TIME_MAX : soonest_due;
    release_q.push_back(r);
  endtask

  // Send one command word: optional idle gap, then hold valid until the block
  // takes the word. Valid stays high on return so back-to-back words stream.
  task automatic send_word(input logic cmd, input logic [tpes_pkg::LEVEL_BITS-1:0] lvl,
                           input logic [tpes_pkg::DELAY_BITS-1:0] dly,
                           input logic [tpes_pkg::INFO_BITS-1:0] info,
                           input logic [tpes_pkg::TAG_BITS-1:0] tag,
                           input logic [tpes_pkg::TIME_BITS-1:0] now);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.level       <= lvl;
    in_ch.delay       <= dly;
    in_ch.event_info  <= info;
    in_ch.handler_tag <= tag;
    in_ch.now         <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_release(cmd, lvl, dly, info, tag, now);
  endtask

  task automatic register_event(input logic [tpes_pkg::LEVEL_BITS-1:0] slot,
                                input logic [tpes_pkg::TIME_BITS-1:0] now,
                                input logic [tpes_pkg::DELAY_BITS-1:0] dly,
                                input logic [tpes_pkg::INFO_BITS-1:0] info,
                                input logic [tpes_pkg::TAG_BITS-1:0] tag);
    send_word(tpes_pkg::CMD_REGISTER, slot, dly, info, tag, now);
  endtask

  // Fire words carry random filler in the fields the block ignores.
  task automatic fire_level(input logic [tpes_pkg::LEVEL_BITS-1:0] lvl,
                            input logic [tpes_pkg::TIME_BITS-1:0] now);
    send_word(tpes_pkg::CMD_FIRE, lvl, tpes_pkg::DELAY_BITS'($urandom),
              tpes_pkg::INFO_BITS'($urandom), tpes_pkg::TAG_BITS'($urandom), now);
  endtask

  // Stop sending and hold off until every owed result has arrived and the
  // block has had time to settle.
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (release_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the mask table; only called with the block idle.
  task automatic set_table(input logic [tpes_pkg::TABLE_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    level_masks = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Release every pending slot: enable all slots at level 0 and fire at the
  // latest possible time once per slot.
  task automatic flush_slots;
    drain();
    set_table('1);
    repeat (tpes_pkg::NUM_SLOTS) fire_level(3'd0, tpes_pkg::TIME_MAX);
    drain();
  endtask

  // Random traffic around a moving tick: mostly registers with short delays and
  // fires at the current tick so events really come due, some fires at the end
  // of time to clear long waits, and a little noise with arbitrary fields.
  task automatic run_traffic(input int count);
    logic [tpes_pkg::TIME_BITS-1:0] tick;
    int pick;
    if ($urandom_range(3) == 0) tick = {16'($urandom), 32'($urandom)};
    else tick = {16'h0, 32'($urandom)};
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        send_word(1'($urandom), 3'($urandom), tpes_pkg::DELAY_BITS'($urandom),
                  tpes_pkg::INFO_BITS'($urandom), tpes_pkg::TAG_BITS'($urandom),
                  {16'($urandom), 32'($urandom)});
      end else if (pick < 50) begin
        register_event(3'($urandom),
                       tick,
                       ($urandom_range(9) == 0) ? tpes_pkg::DELAY_BITS'($urandom)
                                                : tpes_pkg::DELAY_BITS'($urandom_range(60)),
                       tpes_pkg::INFO_BITS'($urandom), tpes_pkg::TAG_BITS'($urandom));
      end else if (pick < 55) begin
        fire_level(3'($urandom), tpes_pkg::TIME_MAX);
      end else begin
        fire_level(3'($urandom), tick);
      end
      tick = tick + tpes_pkg::TIME_BITS'($urandom_range(12));
    end
  endtask

  task automatic test_directed;
    gap_pct   = 0;
    stall_pct = 0;
    fire_level(3'd0, 48'd0);                                // nothing pending
    register_event(3'd0, 48'd100, 32'd50, 16'hFFFF, 8'hFF);
    register_event(3'd0, 48'd100, 32'd0, 16'h1234, 8'h12);  // slot busy: dropped
    register_event(3'd7, 48'd100, 32'd10, 16'h0000, 8'h00);
    fire_level(3'd0, 48'd105);                              // before earliest due
    fire_level(3'd5, 48'd200);                              // level with empty mask
    fire_level(3'd4, 48'd200);                              // slot 0 only
    fire_level(3'd0, 48'd200);                              // last one: all-ones due
    register_event(3'd3, tpes_pkg::TIME_MAX, 32'hFFFF_FFFF, 16'hA5A5, 8'h5A);  // saturates
    register_event(3'd4, tpes_pkg::TIME_MAX - 48'd5, 32'd10, 16'h5A5A, 8'hA5); // saturates
    register_event(3'd5, 48'd0, 32'd0, 16'h0001, 8'h80);
    fire_level(3'd4, tpes_pkg::TIME_MAX);                   // enabled slot not pending
    fire_level(3'd0, 48'd0);
    register_event(3'd0, 48'd0, 32'd500, 16'h00F0, 8'h0F);
    register_event(3'd6, 48'd0, 32'd100, 16'h0F00, 8'hF0);
    fire_level(3'd4, 48'd200);                              // enabled slot not yet due
    register_event(3'd1, 48'd1000, 32'd5, 16'h8000, 8'h01);
    register_event(3'd2, 48'd1000, 32'd1, 16'h7FFF, 8'hFE);
    fire_level(3'd0, 48'd1001);
    fire_level(3'd0, 48'd1001);
    fire_level(3'd0, 48'd1001);
    fire_level(3'd0, 48'd1003);
    fire_level(3'd0, 48'd1005);
    fire_level(3'd3, tpes_pkg::TIME_MAX);
    fire_level(3'd2, tpes_pkg::TIME_MAX);
    fire_level(3'd1, tpes_pkg::TIME_MAX);
  endtask

  task automatic test_zero_table;
    flush_slots();
    set_table('0);
    run_traffic(40);
  endtask

  task automatic test_all_enabled;
    flush_slots();
    set_table('1);
    gap_pct   = 0;
    stall_pct = 0;
    run_traffic(170);
  endtask

  task automatic test_one_slot_per_level;
    flush_slots();
    set_table(64'h8040_2010_0804_0201);
    gap_pct   = 80;
    stall_pct = 0;
    run_traffic(170);
  endtask

  task automatic test_slow_receiver;
    flush_slots();
    set_table({32'($urandom), 32'($urandom)});
    gap_pct   = 0;
    stall_pct = 80;
    run_traffic(170);
  endtask

  task automatic test_mixed_idling;
    flush_slots();
    set_table(tpes_pkg::TABLE_RESET);
    gap_pct   = 36;
    stall_pct = 36;
    run_traffic(170);
  endtask

  // Receiver: drop ready at random according to the current stall rate.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Compare every accepted result word with the oldest prediction.
  always @(posedge clk) begin : check_results
    release_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (release_q.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual fired=%0b slot=%0d",
                 $time, out_ch.fired, out_ch.fired_slot);
        mismatches++;
      end else begin
        want = release_q.pop_front();
        check_field("fired", 64'(want.fired), 64'(out_ch.fired));
        check_field("fired_slot", 64'(want.slot), 64'(out_ch.fired_slot));
        check_field("fired_info", 64'(want.info), 64'(out_ch.fired_info));
        check_field("fired_handler", 64'(want.tag), 64'(out_ch.fired_handler));
        check_field("pending_bits", 64'(want.pending), 64'(out_ch.pending_bits));
        check_field("next_due", 64'(want.next_due), 64'(out_ch.next_due));
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("timed_priority_event_scheduler_test: FAIL");
    $finish;
  end

  initial begin
    // Hold every input at a known value from time zero.
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.command     <= tpes_pkg::CMD_REGISTER;
    in_ch.level       <= '0;
    in_ch.delay       <= '0;
    in_ch.event_info  <= '0;
    in_ch.handler_tag <= '0;
    in_ch.now         <= '0;

    // Match the block's reset state.
    level_masks = tpes_pkg::TABLE_RESET;
    armed       = '0;
    soonest_due = '0;
    for (int s = 0; s < tpes_pkg::NUM_SLOTS; s++) begin
      slot_due[s]  = '0;
      slot_word[s] = '0;
      slot_tag[s]  = '0;
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_zero_table();
    test_all_enabled();
    test_one_slot_per_level();
    test_slow_receiver();
    test_mixed_idling();

    drain();
    if (mismatches == 0 && release_q.size() == 0) begin
      $display("timed_priority_event_scheduler_test: PASS");
    end else begin
      $display("timed_priority_event_scheduler_test: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/tpes_pkg.sv
rtl/tpes_in_if.sv
rtl/tpes_out_if.sv
rtl/tpes_ram.sv
rtl/timed_priority_event_scheduler.sv
test/timed_priority_event_scheduler_test.sv
